/* rtl/rpn_pkg.sv */
// Shared types and constants for the postfix expression evaluator.
// Holds state enums, arithmetic unit request/response structs and symbol codes.
// No dependencies.
`timescale 1ns / 1ps

package rpn_pkg;

  // Arithmetic operations of the shared unit
  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_POW
  } alu_op_t;

  // Sequencer states of the top level
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GET_R,
    ST_POP_L,
    ST_GET_L,
    ST_EXEC,
    ST_WAIT,
    ST_PUSH,
    ST_FIN,
    ST_GET_F
  } ctl_state_t;

  // States of the iterative arithmetic unit
  typedef enum logic [2:0] {
    A_IDLE,
    A_MUL,
    A_DIV,
    A_POW_MUL,
    A_POW_SQR,
    A_DONE
  } alu_state_t;

  typedef struct packed {
    logic        start;
    alu_op_t     op;
    logic [31:0] lhs;
    logic [31:0] rhs;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic        divz;
    logic [31:0] result;
  } alu_rsp_t;

  // Status codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_UNDER = 2'd1;
  localparam logic [1:0] ERR_OVER  = 2'd2;
  localparam logic [1:0] ERR_DIVZ  = 2'd3;

  // Symbol codes
  localparam logic [7:0] SYM_PLUS   = 8'h2B;
  localparam logic [7:0] SYM_MINUS  = 8'h2D;
  localparam logic [7:0] SYM_STAR   = 8'h2A;
  localparam logic [7:0] SYM_SLASH  = 8'h2F;
  localparam logic [7:0] SYM_DOLLAR = 8'h24;
  localparam logic [7:0] SYM_ZERO   = 8'h30;

  localparam logic [31:0] POP_EMPTY = 32'hFFFF_FFFF;

  function automatic logic is_operator(input logic [7:0] sym);
    is_operator = (sym == SYM_PLUS) || (sym == SYM_MINUS) || (sym == SYM_STAR) ||
                  (sym == SYM_SLASH) || (sym == SYM_DOLLAR);
  endfunction

  function automatic alu_op_t op_of(input logic [7:0] sym);
    alu_op_t op;
    op = OP_ADD;
    if (sym == SYM_MINUS) op = OP_SUB;
    if (sym == SYM_STAR) op = OP_MUL;
    if (sym == SYM_SLASH) op = OP_DIV;
    if (sym == SYM_DOLLAR) op = OP_POW;
    op_of = op;
  endfunction

endpackage

/* rtl/rpn_stack_ram.sv */
// Operand stack storage: single write port, one registered read port.
// Read data is registered: it appears in the cycle after the read enable and holds until the next read.
// Depends on nothing.
`timescale 1ns / 1ps

module rpn_stack_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/rpn_alu.sv */
// Iterative arithmetic unit: add, subtract, multiply, restoring divide, power.
// One shared 32x32 multiplier; divide takes one quotient bit per cycle.
// Depends on rpn_pkg.
`timescale 1ns / 1ps

module rpn_alu
  import rpn_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  alu_state_t state, state_next;

  logic [31:0] acc;   // result / power accumulator
  logic [31:0] opb;   // multiplicand, power base, divisor magnitude
  logic [31:0] ex;    // remaining exponent
  logic [31:0] quo;   // dividend shifting into quotient
  logic [31:0] rem;   // partial remainder
  logic [4:0]  cnt;
  logic        neg;
  logic        divz;

  logic [31:0] mul_x;
  logic [31:0] prod;
  logic [32:0] trial;
  logic        ge;
  logic [31:0] q_new;
  logic [31:0] a_mag;
  logic [31:0] b_mag;

  // Shared multiplier and divide step
  always_comb begin
    mul_x = (state == A_POW_SQR) ? opb : acc;
    prod  = mul_x * opb;
    trial = {rem, quo[31]} - {1'b0, opb};
    ge    = ~trial[32];
    q_new = {quo[30:0], ge};
    a_mag = req.lhs[31] ? (32'd0 - req.lhs) : req.lhs;
    b_mag = req.rhs[31] ? (32'd0 - req.rhs) : req.rhs;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      A_IDLE: begin
        if (req.start) begin
          unique case (req.op)
            OP_ADD, OP_SUB: state_next = A_DONE;
            OP_MUL:         state_next = A_MUL;
            OP_DIV:         state_next = (req.rhs == 32'd0) ? A_DONE : A_DIV;
            OP_POW:         state_next = req.rhs[31] ? A_DONE : A_POW_MUL;
            default:        state_next = A_DONE;
          endcase
        end
      end
      A_MUL:     state_next = A_DONE;
      A_DIV:     state_next = (cnt == 5'd31) ? A_DONE : A_DIV;
      A_POW_MUL: state_next = (ex == 32'd0) ? A_DONE : A_POW_SQR;
      A_POW_SQR: state_next = A_POW_MUL;
      A_DONE:    state_next = A_IDLE;
      default:   state_next = A_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    rsp.done   = (state == A_DONE);
    rsp.divz   = divz;
    rsp.result = acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      A_IDLE: begin
        if (req.start) begin
          divz <= 1'b0;
          unique case (req.op)
            OP_ADD: acc <= req.lhs + req.rhs;
            OP_SUB: acc <= req.lhs - req.rhs;
            OP_MUL: begin
              acc <= req.lhs;
              opb <= req.rhs;
            end
            OP_DIV: begin
              if (req.rhs == 32'd0) begin
                acc  <= 32'd0;
                divz <= 1'b1;
              end
              quo <= a_mag;
              opb <= b_mag;
              rem <= 32'd0;
              neg <= req.lhs[31] ^ req.rhs[31];
              cnt <= 5'd0;
            end
            OP_POW: begin
              // negative exponent: only bases 1 and -1 survive
              if (!req.rhs[31]) begin
                acc <= 32'd1;
              end else if (req.lhs == 32'd1) begin
                acc <= 32'd1;
              end else if (req.lhs == POP_EMPTY) begin
                acc <= req.rhs[0] ? POP_EMPTY : 32'd1;
              end else begin
                acc <= 32'd0;
              end
              opb <= req.lhs;
              ex  <= req.rhs;
            end
            default: acc <= 32'd0;
          endcase
        end
      end
      A_MUL: acc <= prod;
      A_DIV: begin
        rem <= ge ? trial[31:0] : {rem[30:0], quo[31]};
        quo <= q_new;
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          acc <= neg ? (32'd0 - q_new) : q_new;
        end
      end
      A_POW_MUL: begin
        if (ex[0]) begin
          acc <= prod;
        end
      end
      A_POW_SQR: begin
        opb <= prod;
        ex  <= {1'b0, ex[31:1]};
      end
      A_DONE: ;
      default: ;
    endcase
  end

endmodule

/* rtl/postfix_expression_evaluator_core.sv */
// Postfix expression evaluator: one character per item, result on the last item.
// A digit is pushed; an operator pops right then left operand, runs the arithmetic
// unit and pushes the result; a last item sends the stack top out once output is free.
// Throughput: one item at a time, bounded by the arithmetic unit loop.
// Reset clears stack count, error code and output valid; stack contents stay
// undefined until pushed, with no clearing pass.
`timescale 1ns / 1ps

module postfix_expression_evaluator_core
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         symbol,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] value,
  output logic [1:0]         status
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  ctl_state_t state, state_next;

  logic [CW-1:0] count;
  logic [1:0]    err;
  logic          cur_last;
  alu_op_t       cur_op;
  logic [31:0]   lhs;
  logic [31:0]   rhs;
  logic [31:0]   push_val;

  logic          accept;
  logic          empty;
  logic          full;
  logic          can_load;
  logic          rd_en;
  logic          pop_dec;
  logic          wr_en;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [31:0]   rd_data;
  logic          err_set;
  logic [1:0]    err_code;
  logic          out_load;
  logic [31:0]   load_value;
  logic [1:0]    load_status;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  assign empty    = (count == '0);
  assign full     = (count >= CW'(STACK_DEPTH));
  assign can_load = ~out_valid | out_ready;
  assign rd_addr  = AW'(count - CW'(1));
  assign wr_addr  = AW'(count);

  rpn_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (push_val),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rpn_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (is_operator(symbol)) begin
            state_next = empty ? ST_POP_L : ST_GET_R;
          end else begin
            state_next = ST_PUSH;
          end
        end
      end
      ST_GET_R: state_next = ST_POP_L;
      ST_POP_L: state_next = empty ? ST_EXEC : ST_GET_L;
      ST_GET_L: state_next = ST_EXEC;
      ST_EXEC:  state_next = ST_WAIT;
      ST_WAIT:  state_next = alu_rsp.done ? ST_PUSH : ST_WAIT;
      ST_PUSH:  state_next = cur_last ? ST_FIN : ST_IDLE;
      ST_FIN: begin
        if (!empty) begin
          state_next = ST_GET_F;
        end else if (can_load) begin
          state_next = ST_IDLE;
        end
      end
      ST_GET_F: state_next = can_load ? ST_IDLE : ST_GET_F;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready      = 1'b0;
    rd_en         = 1'b0;
    pop_dec       = 1'b0;
    wr_en         = 1'b0;
    err_set       = 1'b0;
    err_code      = ERR_NONE;
    out_load      = 1'b0;
    load_value    = rd_data;
    load_status   = err;
    alu_req.start = 1'b0;
    alu_req.op    = cur_op;
    alu_req.lhs   = lhs;
    alu_req.rhs   = rhs;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && is_operator(symbol)) begin
          if (empty) begin
            err_set  = 1'b1;
            err_code = ERR_UNDER;
          end else begin
            rd_en   = 1'b1;
            pop_dec = 1'b1;
          end
        end
      end
      ST_POP_L: begin
        if (empty) begin
          err_set  = 1'b1;
          err_code = ERR_UNDER;
        end else begin
          rd_en   = 1'b1;
          pop_dec = 1'b1;
        end
      end
      ST_EXEC: alu_req.start = 1'b1;
      ST_WAIT: begin
        if (alu_rsp.done && alu_rsp.divz) begin
          err_set  = 1'b1;
          err_code = ERR_DIVZ;
        end
      end
      ST_PUSH: begin
        if (full) begin
          err_set  = 1'b1;
          err_code = ERR_OVER;
        end else begin
          wr_en = 1'b1;
        end
      end
      ST_FIN: begin
        if (!empty) begin
          rd_en = 1'b1;
        end else if (can_load) begin
          out_load    = 1'b1;
          load_value  = POP_EMPTY;
          load_status = (err == ERR_NONE) ? ERR_UNDER : err;
        end
      end
      ST_GET_F: out_load = can_load;
      ST_GET_R, ST_GET_L: ;
      default: ;
    endcase
  end

  assign accept = in_valid & in_ready;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      err       <= ERR_NONE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        count <= '0;
      end else if (pop_dec) begin
        count <= count - CW'(1);
      end else if (wr_en) begin
        count <= count + CW'(1);
      end
      if (out_load) begin
        err <= ERR_NONE;
      end else if (err_set && (err == ERR_NONE)) begin
        err <= err_code;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Operand and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_last <= last;
      cur_op   <= op_of(symbol);
      push_val <= {24'd0, symbol} - {24'd0, SYM_ZERO};
      if (empty) begin
        rhs <= POP_EMPTY;
      end
    end
    if (state == ST_GET_R) begin
      rhs <= rd_data;
    end
    if (state == ST_POP_L && empty) begin
      lhs <= POP_EMPTY;
    end
    if (state == ST_GET_L) begin
      lhs <= rd_data;
    end
    if (state == ST_WAIT && alu_rsp.done) begin
      push_val <= alu_rsp.result;
    end
    if (out_load) begin
      value  <= load_value;
      status <= load_status;
    end
  end

endmodule
